FILE: hdl/mcfb_pkg.sv
// ----------------------------------------------------------------------------
// mcfb_pkg
// Shared types, constants and the CRC helper for the motor command frame
// builder.
// ----------------------------------------------------------------------------
package mcfb_pkg;

  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  // Byte positions in the frame
  localparam logic [IDX_W-1:0] BYTE_ADDR    = IDX_W'(0);
  localparam logic [IDX_W-1:0] BYTE_FCODE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] BYTE_SPEED_H = IDX_W'(2);
  localparam logic [IDX_W-1:0] BYTE_SPEED_L = IDX_W'(3);
  localparam logic [IDX_W-1:0] BYTE_MARK    = IDX_W'(7);
  localparam logic [IDX_W-1:0] BYTE_CRC     = IDX_W'(FRAME_LEN - 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_CODE = 8'd1;

  localparam logic [14:0] SPEED_LIMIT_RST   = 15'd330;
  localparam logic [7:0]  FUNCTION_CODE_RST = 8'h64;

  localparam logic [7:0] CRC_POLY   = 8'h8C;
  localparam logic [7:0] BRAKE_MARK = 8'hFF;
  localparam logic [7:0] RUN_MARK   = 8'h00;

  // One classified command, ready for serialization
  typedef struct packed {
    logic [7:0]  addr;
    logic [7:0]  fcode;
    logic [15:0] speed_word;
    logic        brake;
  } cmd_t;

  // CRC-8/MAXIM, one byte, reflected form
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/mcfb_front.sv
// ----------------------------------------------------------------------------
// mcfb_front
// Accepts commands, holds the configuration registers, saturates the speed
// and registers the classified command for the queue.
// ----------------------------------------------------------------------------
module mcfb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_motor_address,
  input  logic signed [15:0]                in_speed_rpm,
  input  logic                              in_brake,
  input  logic                              cfg_we,
  input  logic [mcfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcfb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              push_valid,
  output mcfb_pkg::cmd_t                    push_cmd,
  input  logic                              q_full
);

  logic [14:0]        speed_limit_r;
  logic [7:0]         function_code_r;
  logic               valid_r, valid_nxt;
  mcfb_pkg::cmd_t     cmd_r, cmd_nxt;
  logic signed [16:0] spd_ext, lim_pos, lim_neg, spd_sat;
  logic               take;

  assign in_stall   = valid_r && q_full;
  assign take       = in_valid && !in_stall;
  assign push_valid = valid_r;
  assign push_cmd   = cmd_r;

  always_comb begin
    spd_ext = {in_speed_rpm[15], in_speed_rpm};
    lim_pos = signed'({2'b00, speed_limit_r});
    lim_neg = -lim_pos;
    if (spd_ext > lim_pos) begin
      spd_sat = lim_pos;
    end else if (spd_ext < lim_neg) begin
      spd_sat = lim_neg;
    end else begin
      spd_sat = spd_ext;
    end
    cmd_nxt.addr       = in_motor_address;
    cmd_nxt.fcode      = function_code_r;
    cmd_nxt.brake      = in_brake;
    cmd_nxt.speed_word = in_brake ? 16'h0000 : spd_sat[15:0];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r   <= mcfb_pkg::SPEED_LIMIT_RST;
      function_code_r <= mcfb_pkg::FUNCTION_CODE_RST;
      valid_r         <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mcfb_pkg::CFG_SPEED_LIMIT:   speed_limit_r   <= cfg_data[14:0];
          mcfb_pkg::CFG_FUNCTION_CODE: function_code_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

FILE: hdl/mcfb_queue.sv
// ----------------------------------------------------------------------------
// mcfb_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module mcfb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mcfb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output mcfb_pkg::cmd_t head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  mcfb_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hdl/mcfb_back.sv
// ----------------------------------------------------------------------------
// mcfb_back
// Serializes the head command into ten frame bytes, one per cycle unless
// stalled, with a running CRC, through a registered output stage.
// ----------------------------------------------------------------------------
module mcfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mcfb_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_frame_byte,
  output logic           out_last
);

  logic [mcfb_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]                 crc_r, crc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 byte_r, byte_sel;
  logic                       last_r;
  logic                       adv, is_last;

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_last       = last_r;

  // advance when a command is queued and the output register is free or being drained
  assign adv     = !q_empty && (!out_valid_r || !out_stall);
  assign is_last = (idx_r == mcfb_pkg::BYTE_CRC);
  assign pop     = adv && is_last;

  always_comb begin
    case (idx_r)
      mcfb_pkg::BYTE_ADDR:    byte_sel = head_cmd.addr;
      mcfb_pkg::BYTE_FCODE:   byte_sel = head_cmd.fcode;
      mcfb_pkg::BYTE_SPEED_H: byte_sel = head_cmd.speed_word[15:8];
      mcfb_pkg::BYTE_SPEED_L: byte_sel = head_cmd.speed_word[7:0];
      mcfb_pkg::BYTE_MARK:    byte_sel = head_cmd.brake ? mcfb_pkg::BRAKE_MARK
                                                        : mcfb_pkg::RUN_MARK;
      mcfb_pkg::BYTE_CRC:     byte_sel = crc_r;
      default:                byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
      if (is_last) begin
        idx_nxt = '0;
        crc_nxt = 8'h00;
      end else begin
        idx_nxt = idx_r + mcfb_pkg::IDX_W'(1);
        crc_nxt = mcfb_pkg::crc8_byte(crc_r, byte_sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r <= byte_sel;
      last_r <= is_last;
    end
  end

endmodule

FILE: hdl/motor_command_frame_builder_core.sv
// ----------------------------------------------------------------------------
// motor_command_frame_builder_core
// Builds a ten-byte motor bus frame with CRC-8/MAXIM from each command.
// ----------------------------------------------------------------------------
// Each accepted command produces ten frame bytes on the output channel, one
// per cycle unless stalled, the tenth (CRC byte) flagged by out_last. The
// next queued command starts once the current CRC byte is loaded. Commands
// enter a front stage that saturates the speed to the speed_limit register
// and latches the function code, then wait in a short queue (QUEUE_DEPTH
// entries) so the input keeps flowing while a frame is still going out. A
// command passes the front register, a queue entry and the output register
// before its first byte appears. Configuration writes are always ready and
// take effect for commands accepted afterwards; unmapped indexes are ignored.
module motor_command_frame_builder_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_motor_address,
  input  logic signed [15:0]              in_speed_rpm,
  input  logic                            in_brake,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_frame_byte,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mcfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcfb_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           push_valid, q_full, q_empty, pop;
  mcfb_pkg::cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  mcfb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_motor_address (in_motor_address),
    .in_speed_rpm     (in_speed_rpm),
    .in_brake         (in_brake),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push_valid       (push_valid),
    .push_cmd         (push_cmd),
    .q_full           (q_full)
  );

  mcfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  mcfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last)
  );

endmodule

FILE: tb/sv/tb_motor_command_frame_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_command_frame_builder_core
// Self-checking bench for the motor command frame builder. Commands go in
// through directed corner cases and then through random bursts under several
// register settings. Each command's ten frame bytes, including the
// CRC-8/MAXIM trailer, are predicted here and checked in order against the
// output channel while the output side stalls at random.
// ----------------------------------------------------------------------------
module tb_motor_command_frame_builder_core;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam logic [7:0] CFG_FIRST_UNUSED = mcfb_pkg::CFG_FUNCTION_CODE + 8'd1;
  localparam logic [7:0] CFG_LAST_INDEX = 8'hFF;

  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  class frame_scoreboard;
    logic [14:0] speed_limit;
    logic [7:0]  function_code;
    frame_byte_t pending_bytes[$];
    int unsigned commands;
    int unsigned brake_frames;
    int unsigned clamped;
    int unsigned bytes_seen;
    int unsigned errors;

    function new();
      speed_limit   = mcfb_pkg::SPEED_LIMIT_RST;
      function_code = mcfb_pkg::FUNCTION_CODE_RST;
      commands      = 0;
      brake_frames  = 0;
      clamped       = 0;
      bytes_seen    = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic [7:0] index, logic [15:0] data);
      case (index)
        mcfb_pkg::CFG_SPEED_LIMIT:   speed_limit = data[14:0];
        mcfb_pkg::CFG_FUNCTION_CODE: function_code = data[7:0];
        default: ;
      endcase
    endfunction

    // Build the whole frame for one accepted command and queue its bytes.
    function void note_command(logic [7:0] addr, logic signed [15:0] speed, logic brake);
      logic [7:0] frame [mcfb_pkg::FRAME_LEN];
      logic [7:0] crc;
      frame_byte_t fb;
      int lim;
      int clipped;
      lim = speed_limit;
      clipped = speed;
      if (clipped > lim) clipped = lim;
      if (clipped < -lim) clipped = -lim;
      commands++;
      if (brake) brake_frames++;
      else if (clipped != int'(speed)) clamped++;
      frame[0] = addr;
      frame[1] = function_code;
      frame[2] = brake ? 8'h00 : clipped[15:8];
      frame[3] = brake ? 8'h00 : clipped[7:0];
      frame[4] = 8'h00;
      frame[5] = 8'h00;
      frame[6] = 8'h00;
      frame[7] = brake ? mcfb_pkg::BRAKE_MARK : mcfb_pkg::RUN_MARK;
      frame[8] = 8'h00;
      // Bit-serial, LSB first, over the nine header bytes
      crc = 8'h00;
      for (int i = 0; i < mcfb_pkg::FRAME_LEN - 1; i++) begin
        for (int b = 0; b < 8; b++) begin
          if (crc[0] ^ frame[i][b]) crc = (crc >> 1) ^ mcfb_pkg::CRC_POLY;
          else crc = crc >> 1;
        end
      end
      frame[mcfb_pkg::FRAME_LEN - 1] = crc;
      for (int k = 0; k < mcfb_pkg::FRAME_LEN; k++) begin
        fb.data = frame[k];
        fb.last = (k == mcfb_pkg::FRAME_LEN - 1);
        pending_bytes.push_back(fb);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_byte_t want;
      if (pending_bytes.size() == 0) begin
        $error("unexpected frame byte %02h (last %0b)", data, last);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      bytes_seen++;
      if (data !== want.data) begin
        $error("frame_byte: expected %02h, actual %02h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_motor_address = 8'h00;
  logic signed [15:0] in_speed_rpm = 16'sh0000;
  logic in_brake = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_frame_byte;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mcfb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mcfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  frame_scoreboard sb;
  int unsigned settings_seen = 1;

  always #1 clk = ~clk;

  motor_command_frame_builder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_motor_address (in_motor_address),
    .in_speed_rpm     (in_speed_rpm),
    .in_brake         (in_brake),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  task automatic send_command(input logic [7:0] addr, input logic signed [15:0] speed,
                              input logic brake);
    in_valid         <= 1'b1;
    in_motor_address <= addr;
    in_speed_rpm     <= speed;
    in_brake         <= brake;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(addr, speed, brake);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid         <= 1'b0;
    in_motor_address <= 8'($urandom_range(0, 255));
    in_speed_rpm     <= 16'($urandom_range(0, 65535));
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the input until every queued frame byte has been transferred.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(index, data);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    settings_seen++;
  endtask

  task automatic run_random(input int unsigned count, input bit hold_midway);
    int unsigned burst;
    int unsigned pick;
    int lim;
    int s;
    logic brake;
    burst = $urandom_range(1, 10);
    for (int unsigned i = 0; i < count; i++) begin
      lim = sb.speed_limit;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        s = int'($urandom_range(0, 2 * lim + 4)) - lim - 2;
      end else if (pick < 6) begin
        // right at the limit or one past it
        s = lim + int'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) s = -s;
      end else if (pick < 9) begin
        s = $urandom_range(0, 65535);
      end else begin
        s = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      end
      brake = ($urandom_range(0, 3) == 0);
      send_command(8'($urandom_range(0, 255)), s[15:0], brake);
      burst = burst - 1;
      if (hold_midway && i == count / 2) begin
        drain();
      end else if (burst == 0) begin
        pause_sender($urandom_range(1, 12));
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
      end
    end
  endtask

  // Output side: stall on its own schedule of quiet, light, half and heavy stretches.
  initial begin : stall_pattern
    stall_mode_t mode;
    int unsigned span;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
          default:     out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_byte(out_frame_byte, out_last);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: limit 330, default function code
    send_command(8'h00, 16'sd0, 1'b0);
    send_command(8'hFF, 16'sd32767, 1'b0);
    send_command(8'hA5, 16'sh8000, 1'b0);
    send_command(8'h5A, 16'sd330, 1'b0);
    send_command(8'h01, 16'sd331, 1'b0);
    send_command(8'h80, -16'sd330, 1'b0);
    send_command(8'h7F, -16'sd331, 1'b0);
    send_command(8'h12, -16'sd1, 1'b0);
    send_command(8'h34, 16'sd1, 1'b0);
    send_command(8'hFF, 16'sd32767, 1'b1);
    send_command(8'h00, 16'sh8000, 1'b1);
    pause_sender(3);
    send_command(8'hC3, 16'sd0, 1'b1);
    drain();

    // Largest limit; bit 15 of the data must be dropped
    write_reg(mcfb_pkg::CFG_SPEED_LIMIT, 16'hFFFF);
    write_reg(mcfb_pkg::CFG_FUNCTION_CODE, 16'hFFFF);
    end_writes();
    send_command(8'h11, 16'sh8000, 1'b0);
    send_command(8'h22, 16'sd32767, 1'b0);
    send_command(8'h33, -16'sd32767, 1'b0);
    send_command(8'h44, 16'sh8000, 1'b1);
    drain();

    // Zero limit; writes to unmapped indexes leave both registers alone
    write_reg(mcfb_pkg::CFG_SPEED_LIMIT, 16'h0000);
    write_reg(mcfb_pkg::CFG_FUNCTION_CODE, 16'h0000);
    write_reg(CFG_FIRST_UNUSED, 16'hFFFF);
    write_reg(CFG_LAST_INDEX, 16'h5555);
    end_writes();
    send_command(8'h55, 16'sd1, 1'b0);
    send_command(8'h66, -16'sd1, 1'b0);
    send_command(8'h77, 16'sd32767, 1'b0);
    send_command(8'h88, 16'sh8000, 1'b0);
    send_command(8'h99, 16'sd100, 1'b1);
    drain();

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_reg(mcfb_pkg::CFG_SPEED_LIMIT, 16'($urandom_range(1, 1000)));
        1: write_reg(mcfb_pkg::CFG_SPEED_LIMIT, 16'h7FFF);
        2: write_reg(mcfb_pkg::CFG_SPEED_LIMIT, 16'h0000);
        3: write_reg(mcfb_pkg::CFG_SPEED_LIMIT, 16'h8000 | 16'(mcfb_pkg::SPEED_LIMIT_RST));
        default: write_reg(mcfb_pkg::CFG_SPEED_LIMIT, 16'($urandom_range(0, 65535)));
      endcase
      if (p == 3) write_reg(mcfb_pkg::CFG_FUNCTION_CODE, 16'(mcfb_pkg::FUNCTION_CODE_RST));
      else write_reg(mcfb_pkg::CFG_FUNCTION_CODE, 16'($urandom_range(0, 65535)));
      write_reg(8'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
                16'($urandom_range(0, 65535)));
      end_writes();
      run_random(ITEMS_PER_PHASE, p == 0);
      drain();
    end

    $display("covered %0d commands (%0d brake, %0d clamped) across %0d register settings",
             sb.commands, sb.brake_frames, sb.clamped, settings_seen);
    $display("checked %0d frame bytes, %0d mismatches", sb.bytes_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("timeout waiting for frame bytes");
    $display("status: fail");
    $finish;
  end

endmodule
